// ===== src/napt_pkg.sv =====
// ----------------------------------------------------------------------------
// napt_pkg
// Shared types and constants for the nearest active proximity trigger.
// ----------------------------------------------------------------------------
package napt_pkg;

   localparam int COORD_W = 16;
   localparam int ABS_W   = 16;
   localparam int SQ_W    = 2 * ABS_W;
   localparam int DIST_W  = SQ_W + 2;
   localparam int RAD_W   = 16;
   localparam int R2_W    = 2 * RAD_W;
   localparam int NBR_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOURS = 2'd1;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [RAD_W-1:0] RADIUS_RESET     = 16'd1500;
   localparam logic [NBR_W-1:0] NEIGHBOURS_RESET = 4'd3;

   typedef struct packed {
      logic                      active;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } napt_point_type;

   localparam int POINT_W = $bits(napt_point_type);

   typedef struct packed {
      logic              valid;
      logic              active;
      logic [DIST_W-1:0] sq_dist;
   } napt_entry_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } napt_pos_type;

endpackage

// ===== src/napt_ram.sv =====
// ----------------------------------------------------------------------------
// napt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module napt_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/napt_dist.sv =====
// ----------------------------------------------------------------------------
// napt_dist
// Three-stage pipeline that forms the squared 3D distance of a stored point.
// ----------------------------------------------------------------------------
module napt_dist (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  napt_pkg::napt_point_type point,
   input  napt_pkg::napt_pos_type   query,
   output logic                    busy,
   output napt_pkg::napt_entry_type cand
);
   import napt_pkg::*;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s1_act_ff, s2_act_ff, s3_act_ff;
   logic [ABS_W-1:0]  s1_ax_ff, s1_ay_ff, s1_az_ff;
   logic [ABS_W-1:0]  s1_ax_in, s1_ay_in, s1_az_in;
   logic [SQ_W-1:0]   s2_qx_ff, s2_qy_ff, s2_qz_ff;
   logic [DIST_W-1:0] s3_dist_ff;

   function automatic logic [ABS_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic signed [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? -d : d;
      return m[ABS_W-1:0];
   endfunction

   always_comb begin
      s1_ax_in = abs_diff(point.x, query.x);
      s1_ay_in = abs_diff(point.y, query.y);
      s1_az_in = abs_diff(point.z, query.z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_ax_ff   <= s1_ax_in;
      s1_ay_ff   <= s1_ay_in;
      s1_az_ff   <= s1_az_in;
      s1_act_ff  <= point.active;
      s2_qx_ff   <= s1_ax_ff * s1_ax_ff;
      s2_qy_ff   <= s1_ay_ff * s1_ay_ff;
      s2_qz_ff   <= s1_az_ff * s1_az_ff;
      s2_act_ff  <= s1_act_ff;
      s3_dist_ff <= DIST_W'(s2_qx_ff) + DIST_W'(s2_qy_ff) + DIST_W'(s2_qz_ff);
      s3_act_ff  <= s2_act_ff;
   end

   assign busy         = s1_valid_ff | s2_valid_ff;
   assign cand.valid   = s3_valid_ff;
   assign cand.active  = s3_act_ff;
   assign cand.sq_dist = s3_dist_ff;

endmodule

// ===== src/napt_cell.sv =====
// ----------------------------------------------------------------------------
// napt_cell
// One slot of the sorted nearest-neighbor chain with insert and shift logic.
// ----------------------------------------------------------------------------
module napt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     load,
   input  logic                     enable,
   input  logic [napt_pkg::R2_W-1:0] r2,
   input  napt_pkg::napt_entry_type cand,
   input  napt_pkg::napt_entry_type prev,
   input  logic                     prev_ins,
   output napt_pkg::napt_entry_type cur,
   output logic                     ins,
   output logic                     hit
);
   import napt_pkg::*;

   napt_entry_type cur_ff;

   // Equal distances do not displace an entry, so earlier points rank first.
   assign ins = !cur_ff.valid || (cand.sq_dist < cur_ff.sq_dist);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         cur_ff.valid <= 1'b0;
      end else if (load && ins) begin
         cur_ff <= prev_ins ? prev : cand;
      end
   end

   assign cur = cur_ff;
   assign hit = enable && cur_ff.valid && cur_ff.active &&
                (cur_ff.sq_dist < DIST_W'(r2));

endmodule

// ===== src/nearest_active_proximity_trigger_top.sv =====
// ----------------------------------------------------------------------------
// nearest_active_proximity_trigger_top
// Point table with a query that tests the nearest stored points for activity.
// ----------------------------------------------------------------------------
// An append transfer writes the point into the table RAM. A query transfer
// occupies the block while the single read port of the table walks the stored
// points one per cycle, each passes a three-stage distance pipeline, and a
// chain of MAX_NEIGHBOURS cells keeps the nearest ones sorted. New transfers
// are taken while an earlier result still waits on the response channel.
module nearest_active_proximity_trigger_top #(
   parameter int MAX_POINTS     = 64,
   parameter int MAX_NEIGHBOURS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: pos_x[15:0], pos_y[31:16], pos_z[47:32], is_active[48], zero pad.
   input  logic [55:0] req_tdata,
   // tuser: op[0], first[1].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: triggered[0], zero pad.
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [napt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);
   import napt_pkg::*;

   localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff;
   logic [RAD_W-1:0] radius_ff;
   logic [NBR_W-1:0] nbr_ff;
   logic [R2_W-1:0]  r2_ff;
   napt_pos_type     query_ff;
   logic             rsp_valid_ff;
   logic             rsp_trig_ff;

   logic             req_fire, is_append, is_query, first_bit;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   napt_point_type   wr_point;
   napt_point_type   rd_point;
   napt_pos_type     req_pos;
   logic             issue, drained, rsp_free, rsp_load, dist_busy, trig;
   napt_entry_type   cand;

   napt_entry_type             cell_cur [MAX_NEIGHBOURS];
   logic [MAX_NEIGHBOURS-1:0]  cell_ins;
   logic [MAX_NEIGHBOURS-1:0]  cell_hit;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign is_append  = req_fire && (req_tuser[0] == OP_APPEND);
   assign is_query   = req_fire && (req_tuser[0] == OP_QUERY);
   assign first_bit  = req_tuser[1];

   assign req_pos.x = req_tdata[15:0];
   assign req_pos.y = req_tdata[31:16];
   assign req_pos.z = req_tdata[47:32];

   assign wr_point.x      = req_pos.x;
   assign wr_point.y      = req_pos.y;
   assign wr_point.z      = req_pos.z;
   assign wr_point.active = req_tdata[48];

   assign wr_en   = is_append && (first_bit || (count_ff < CNT_W'(MAX_POINTS)));
   assign wr_addr = first_bit ? '0 : count_ff[AW-1:0];

   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = first_bit ? CNT_W'(1) : count_ff + CNT_W'(1);
      end
   end

   assign issue    = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff);
   assign drained  = (state_ff == ST_SCAN) && !issue && !rd_vld_ff && !dist_busy &&
                     !cand.valid;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = drained && rsp_free;
   assign trig     = |cell_hit;

   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_query) begin
               state_in  = ST_SCAN;
               rd_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         radius_ff    <= RADIUS_RESET;
         nbr_ff       <= NEIGHBOURS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         rd_vld_ff <= issue;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_RADIUS:     radius_ff <= csr_data;
               CSR_NEIGHBOURS: nbr_ff    <= csr_data[NBR_W-1:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      r2_ff <= radius_ff * radius_ff;
      if (is_query) begin
         query_ff <= req_pos;
      end
      if (rsp_load) begin
         rsp_trig_ff <= trig;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_trig_ff};

   napt_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS),
      .ADDR_W(AW)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_point),
      .rd_en  (issue),
      .rd_addr(rd_idx_ff[AW-1:0]),
      .rd_data(rd_point)
   );

   napt_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .in_valid(rd_vld_ff),
      .point   (rd_point),
      .query   (query_ff),
      .busy    (dist_busy),
      .cand    (cand)
   );

   for (genvar k = 0; k < MAX_NEIGHBOURS; k++) begin : g_cell
      napt_entry_type prev_entry;
      logic           prev_ins;

      if (k == 0) begin : g_head
         assign prev_entry = '0;
         assign prev_ins   = 1'b0;
      end else begin : g_link
         assign prev_entry = cell_cur[k-1];
         assign prev_ins   = cell_ins[k-1];
      end

      napt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .clear   (is_query),
         .load    (cand.valid),
         .enable  (NBR_W'(k) < nbr_ff),
         .r2      (r2_ff),
         .cand    (cand),
         .prev    (prev_entry),
         .prev_ins(prev_ins),
         .cur     (cell_cur[k]),
         .ins     (cell_ins[k]),
         .hit     (cell_hit[k])
      );
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond table depth");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rd_idx_ff <= count_ff))
      else $error("table walk passed the point count");

   a_result_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rd_vld_ff && !dist_busy && !cand.valid))
      else $error("result taken before the distance pipeline drained");

   a_no_query_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> !$past(is_query))
      else $error("query transfer taken during a table walk");

endmodule
